FILE: hdl/channel_delay_gain_router_assert.svh
// assertion macros shared by the delay-gain router modules
// expects clk and rst_n in the scope of the module that uses them
`ifndef CHANNEL_DELAY_GAIN_ROUTER_ASSERT_SVH
`define CHANNEL_DELAY_GAIN_ROUTER_ASSERT_SVH

// same-cycle implication, off during reset
`define CDGR_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define CDGR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/cdgr_pkg.sv
// types, constants and register codes of the delay-gain router
// no dependencies
package cdgr_pkg;

    localparam int MAX_CHANNELS_DEF = 8;
    localparam int MAX_DELAY_DEF    = 4096;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int GAIN_FRAC_DEF    = 12;

    localparam int NUM_POS     = 8;
    localparam int NUM_OUT     = 8;
    localparam int NUM_BANKS   = 2;
    localparam int POS_W       = 3;
    localparam int OUT_IDX_W   = 3;
    localparam int CNT_W       = 4;
    localparam int GAIN_W      = 16;
    localparam int DLY_FIELD_W = 12;
    localparam int ROUTE_W     = 4;
    localparam int ACC_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CNT_W-1:0]  CC_RST     = 4'd2;
    localparam logic [63:0]       GAINS_RST  = 64'h1000_1000_1000_1000;
    localparam logic [47:0]       DELAYS_RST = 48'h0;
    localparam logic [31:0]       ROUTE_RST  = 32'hFEDC_BA98;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 3'd0,
        REG_GAINS_LOW     = 3'd1,
        REG_GAINS_HIGH    = 3'd2,
        REG_DELAYS_LOW    = 3'd3,
        REG_DELAYS_HIGH   = 3'd4,
        REG_ROUTE_TABLE   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic                        valid;
        logic                        routed;
        logic                        frame_end;
        logic [OUT_IDX_W-1:0]        tgt;
        logic signed [GAIN_W-1:0]    gain;
        logic [CNT_W-1:0]            n;
    } mix_req_t;

endpackage

FILE: hdl/cdgr_if.sv
// valid/ready channel interfaces for input samples and mixed output beats
// depends on cdgr_pkg
interface cdgr_in_if #(
    parameter int SAMPLE_BITS = cdgr_pkg::SAMPLE_BITS_DEF
) ();
    import cdgr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface cdgr_out_if #(
    parameter int SAMPLE_BITS = cdgr_pkg::SAMPLE_BITS_DEF
) ();
    import cdgr_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic [OUT_IDX_W-1:0]          out_channel;
    logic                          frame_last;

    modport source (output valid, output sample_out, output out_channel, output frame_last,
                    input ready);
    modport sink (input valid, input sample_out, input out_channel, input frame_last,
                  output ready);
endinterface

FILE: hdl/cdgr_delay.sv
// circular delay lines in one synchronous memory, with pointers and fill counts
// depends on cdgr_pkg and channel_delay_gain_router_assert.svh
`include "channel_delay_gain_router_assert.svh"

module cdgr_delay #(
    parameter int MAX_CHANNELS_P = cdgr_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_DELAY      = cdgr_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS    = cdgr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                we,
    input  logic [cdgr_pkg::POS_W-1:0]          pos,
    input  logic [cdgr_pkg::DLY_FIELD_W-1:0]    len_field,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic signed [SAMPLE_BITS-1:0]       old_sample
);
    import cdgr_pkg::*;

    localparam int NPOS   = (MAX_CHANNELS_P < NUM_POS) ? MAX_CHANNELS_P : NUM_POS;
    localparam int PIDX_W = (NPOS > 1) ? $clog2(NPOS) : 1;
    localparam int PTR_W  = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
    localparam int LEN_W  = $clog2(MAX_DELAY + 1);
    localparam int DEPTH  = NPOS * MAX_DELAY;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PTR_W-1:0]              ptr_reg  [NPOS];
    logic [LEN_W-1:0]              fill_reg [NPOS];
    logic signed [SAMPLE_BITS-1:0] mem      [DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic                          hit_reg;

    logic [PIDX_W-1:0]      pidx;
    logic [DLY_FIELD_W:0]   raw_len;
    logic [LEN_W-1:0]       len;
    logic [PTR_W-1:0]       ptr_cur;
    logic [LEN_W-1:0]       fill_cur;
    logic [LEN_W-1:0]       ptr_inc;
    logic                   hit;
    logic [PTR_W-1:0]       ptr_next;
    logic [LEN_W-1:0]       fill_next;
    logic [ADDR_W-1:0]      addr;

    always_comb
    begin
        pidx    = PIDX_W'(pos);
        raw_len = {1'b0, len_field} + (DLY_FIELD_W + 1)'(1);
        if (32'(raw_len) > MAX_DELAY)
        begin
            len = LEN_W'(MAX_DELAY);
        end
        else
        begin
            len = LEN_W'(raw_len);
        end
        ptr_cur   = ptr_reg[pidx];
        fill_cur  = fill_reg[pidx];
        ptr_inc   = LEN_W'(ptr_cur) + LEN_W'(1);
        hit       = LEN_W'(ptr_cur) < fill_cur;
        ptr_next  = (ptr_inc >= len) ? '0 : PTR_W'(ptr_inc);
        fill_next = hit ? fill_cur : ptr_inc;
        addr      = ADDR_W'(pidx) * ADDR_W'(MAX_DELAY) + ADDR_W'(ptr_cur);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NPOS; i++)
            begin
                ptr_reg[i]  <= '0;
                fill_reg[i] <= '0;
            end
            hit_reg <= 1'b0;
        end
        else if (we)
        begin
            ptr_reg[pidx]  <= ptr_next;
            fill_reg[pidx] <= fill_next;
            hit_reg        <= hit;
        end
    end

    // read-first: the oldest sample leaves as the new one takes its slot
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rd_reg    <= mem[addr];
            mem[addr] <= sample;
        end
    end

    // slots never written since reset read as silence
    assign old_sample = hit_reg ? rd_reg : '0;

    `CDGR_ASSERT_NEXT(a_fill_after_write, we, fill_reg[$past(pidx)] != '0, "line empty after write")
    `CDGR_ASSERT_NEXT(a_ptr_in_prefix, we, LEN_W'(ptr_reg[$past(pidx)]) <= fill_reg[$past(pidx)], "pointer beyond written prefix")
    `CDGR_ASSERT_NEXT(a_ptr_wrap, we && (ptr_inc >= len), ptr_reg[$past(pidx)] == '0, "pointer kept past length")

endmodule

FILE: hdl/cdgr_mix.sv
// gain multiply, banked accumulator memory and frame output drain
// depends on cdgr_pkg, cdgr_if and channel_delay_gain_router_assert.svh
`include "channel_delay_gain_router_assert.svh"

module cdgr_mix #(
    parameter int SAMPLE_BITS = cdgr_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC   = cdgr_pkg::GAIN_FRAC_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdgr_pkg::mix_req_t            req,
    input  logic signed [SAMPLE_BITS-1:0] old_sample,
    output logic                          bank_free,
    cdgr_out_if.source                    mix_ch
);
    import cdgr_pkg::*;

    localparam int PROD_W   = SAMPLE_BITS + GAIN_W;
    localparam int SUM_W    = ((PROD_W > ACC_W) ? PROD_W : ACC_W) + 1;
    localparam int ACC_AW   = 1 + OUT_IDX_W;
    localparam int ACC_DEPTH = NUM_BANKS * NUM_OUT;
    localparam int RND_HALF = 1 << (GAIN_FRAC - 1);
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

    // bank bookkeeping
    logic                  cur_bank_reg;
    logic [NUM_BANKS-1:0]  full_reg;
    logic [CNT_W-1:0]      n_reg [NUM_BANKS];

    // multiply stage
    logic                     s1_valid_reg;
    logic                     s1_routed_reg;
    logic                     s1_bank_reg;
    logic [OUT_IDX_W-1:0]     s1_tgt_reg;
    logic signed [GAIN_W-1:0] s1_gain_reg;

    // accumulate stage
    logic                     s2_valid_reg;
    logic                     s2_routed_reg;
    logic                     s2_bank_reg;
    logic [OUT_IDX_W-1:0]     s2_tgt_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;
    logic signed [ACC_W-1:0]  acc_rd_reg;
    logic                     acc_hit_reg;

    logic signed [ACC_W-1:0]  acc_mem [ACC_DEPTH];
    logic [NUM_OUT-1:0]       acc_valid_reg [NUM_BANKS];

    // drain
    logic                     em_bank_reg;
    logic [OUT_IDX_W-1:0]     em_idx_reg;
    logic                     rd_pend_reg;
    logic signed [ACC_W-1:0]  em_rd_reg;
    logic                     em_hit_reg;
    logic [OUT_IDX_W-1:0]     em_ch_reg;
    logic                     em_last_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic [OUT_IDX_W-1:0]          out_channel_reg;
    logic                          out_last_reg;

    logic                     inflight;
    logic                     em_issue;
    logic                     em_last;
    logic [ACC_AW-1:0]        s1_addr;
    logic [ACC_AW-1:0]        s2_addr;
    logic [ACC_AW-1:0]        em_addr;
    logic                     acc_we;
    logic signed [PROD_W-1:0] mul_a;
    logic signed [PROD_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [PROD_W-1:0] prod_q;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [SUM_W-1:0]  acc_sum;
    logic signed [ACC_W-1:0]  acc_new;
    logic signed [ACC_W-1:0]  em_val;
    logic signed [SAMPLE_BITS-1:0] em_sat;

    always_comb
    begin
        inflight = (s1_valid_reg && (s1_bank_reg == em_bank_reg)) ||
                   (s2_valid_reg && (s2_bank_reg == em_bank_reg));
        em_issue = full_reg[em_bank_reg] && !inflight && !rd_pend_reg &&
                   (!out_valid_reg || mix_ch.ready);
        em_last  = (CNT_W'(em_idx_reg) + CNT_W'(1)) == n_reg[em_bank_reg];
        bank_free = !full_reg[cur_bank_reg] ||
                    (em_issue && em_last && (em_bank_reg == cur_bank_reg));

        s1_addr = {s1_bank_reg, s1_tgt_reg};
        s2_addr = {s2_bank_reg, s2_tgt_reg};
        em_addr = {em_bank_reg, em_idx_reg};
        acc_we  = s2_valid_reg && s2_routed_reg;

        mul_a = PROD_W'(old_sample);
        mul_b = PROD_W'(s1_gain_reg);

        // round to nearest, ties up
        prod_rnd = s2_prod_reg + PROD_W'(RND_HALF);
        prod_q   = prod_rnd >>> GAIN_FRAC;
        acc_base = acc_hit_reg ? acc_rd_reg : '0;
        acc_sum  = SUM_W'(acc_base) + SUM_W'(prod_q);
        if (acc_sum > SUM_MAX)
        begin
            acc_new = ACC_W'(SUM_MAX);
        end
        else if (acc_sum < SUM_MIN)
        begin
            acc_new = ACC_W'(SUM_MIN);
        end
        else
        begin
            acc_new = ACC_W'(acc_sum);
        end

        em_val = em_hit_reg ? em_rd_reg : '0;
        if (em_val > OUT_MAX)
        begin
            em_sat = SAMPLE_BITS'(OUT_MAX);
        end
        else if (em_val < OUT_MIN)
        begin
            em_sat = SAMPLE_BITS'(OUT_MIN);
        end
        else
        begin
            em_sat = SAMPLE_BITS'(em_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_bank_reg  <= 1'b0;
            full_reg      <= '0;
            for (int b = 0; b < NUM_BANKS; b++)
            begin
                n_reg[b]         <= '0;
                acc_valid_reg[b] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            s1_routed_reg <= 1'b0;
            s1_bank_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_routed_reg <= 1'b0;
            s2_bank_reg   <= 1'b0;
            em_bank_reg   <= 1'b0;
            em_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= req.valid;
            s1_routed_reg <= req.valid && req.routed;
            if (req.valid)
            begin
                s1_bank_reg <= cur_bank_reg;
            end
            s2_valid_reg  <= s1_valid_reg;
            s2_routed_reg <= s1_routed_reg;
            s2_bank_reg   <= s1_bank_reg;

            if (acc_we)
            begin
                acc_valid_reg[s2_bank_reg][s2_tgt_reg] <= 1'b1;
            end

            rd_pend_reg <= em_issue;
            if (em_issue)
            begin
                if (em_last)
                begin
                    em_idx_reg                 <= '0;
                    em_bank_reg                <= ~em_bank_reg;
                    full_reg[em_bank_reg]      <= 1'b0;
                    acc_valid_reg[em_bank_reg] <= '0;
                end
                else
                begin
                    em_idx_reg <= em_idx_reg + OUT_IDX_W'(1);
                end
            end

            // a frame end closes the current bank and hands it to the drain
            if (req.valid && req.frame_end)
            begin
                full_reg[cur_bank_reg] <= 1'b1;
                n_reg[cur_bank_reg]    <= req.n;
                cur_bank_reg           <= ~cur_bank_reg;
            end

            if (rd_pend_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (mix_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            s1_tgt_reg  <= req.tgt;
            s1_gain_reg <= req.gain;
        end
        s2_tgt_reg  <= s1_tgt_reg;
        s2_prod_reg <= mul_a * mul_b;
        acc_rd_reg  <= acc_mem[s1_addr];
        acc_hit_reg <= acc_valid_reg[s1_bank_reg][s1_tgt_reg];
        if (acc_we)
        begin
            acc_mem[s2_addr] <= acc_new;
        end
        if (em_issue)
        begin
            em_rd_reg   <= acc_mem[em_addr];
            em_hit_reg  <= acc_valid_reg[em_bank_reg][em_idx_reg];
            em_ch_reg   <= em_idx_reg;
            em_last_reg <= em_last;
        end
        if (rd_pend_reg)
        begin
            out_sample_reg  <= em_sat;
            out_channel_reg <= em_ch_reg;
            out_last_reg    <= em_last_reg;
        end
    end

    assign mix_ch.valid       = out_valid_reg;
    assign mix_ch.sample_out  = out_sample_reg;
    assign mix_ch.out_channel = out_channel_reg;
    assign mix_ch.frame_last  = out_last_reg;

    `CDGR_ASSERT_IMPLIES(a_req_spacing, s1_valid_reg, !req.valid, "samples closer than two cycles")
    `CDGR_ASSERT_IMPLIES(a_drain_no_overlap, em_issue && acc_we, s2_bank_reg != em_bank_reg, "write into draining bank")
    `CDGR_ASSERT_IMPLIES(a_out_slot_free, rd_pend_reg, !out_valid_reg, "output register overrun")

endmodule

FILE: hdl/channel_delay_gain_router.sv
// Multichannel delay and gain router. After an interleaved sample is taken, hold_reg
// holds off the input; each routed sample does one read-modify-write of the banked
// accumulator memory, read in the multiply and written in the accumulate stage.
// Frame results leave one beat at a time, held while the output stalls, through the
// second read port of that memory once no sample of that bank is in those stages;
// two accumulator banks let a new frame mix while the previous one drains, and input
// also stalls while both banks wait for the output side. No clearing pass is needed
// after reset: each delay line keeps a fill count, and slots past it read as zero.
// depends on cdgr_pkg, cdgr_if, cdgr_delay and cdgr_mix
module channel_delay_gain_router #(
    parameter int MAX_CHANNELS_P = cdgr_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_DELAY      = cdgr_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS    = cdgr_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC      = cdgr_pkg::GAIN_FRAC_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wen,
    input  logic [cdgr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cdgr_pkg::CFG_DATA_W-1:0]   cfg_data,
    cdgr_in_if.sink                           sample_ch,
    cdgr_out_if.source                        mix_ch
);
    import cdgr_pkg::*;

    localparam int NPOS = (MAX_CHANNELS_P < NUM_POS) ? MAX_CHANNELS_P : NUM_POS;

    logic [CNT_W-1:0]  cc_reg;
    logic [63:0]       gains_low_reg;
    logic [63:0]       gains_high_reg;
    logic [47:0]       delays_low_reg;
    logic [47:0]       delays_high_reg;
    logic [31:0]       route_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              hold_reg;

    logic                     accept;
    logic                     bank_free;
    logic [CNT_W-1:0]         eff_n;
    logic                     frame_end;
    logic [ROUTE_W-1:0]       route_nib;
    logic                     routed;
    logic [63:0]              gain_sel;
    logic [47:0]              delay_sel;
    logic signed [GAIN_W-1:0] gain;
    logic [DLY_FIELD_W-1:0]   len_field;
    mix_req_t                 req;
    logic signed [SAMPLE_BITS-1:0] old_sample;

    always_comb
    begin
        eff_n = cc_reg;
        if (cc_reg == '0)
        begin
            eff_n = CNT_W'(1);
        end
        else if (int'(cc_reg) > NPOS)
        begin
            eff_n = CNT_W'(NPOS);
        end
        frame_end = (CNT_W'(pos_reg) + CNT_W'(1)) >= eff_n;

        route_nib = route_reg[ROUTE_W*pos_reg +: ROUTE_W];
        routed    = (int'(pos_reg) < NPOS) && route_nib[ROUTE_W-1];
        gain_sel  = pos_reg[POS_W-1] ? gains_high_reg : gains_low_reg;
        delay_sel = pos_reg[POS_W-1] ? delays_high_reg : delays_low_reg;
        gain      = gain_sel[GAIN_W*pos_reg[1:0] +: GAIN_W];
        len_field = delay_sel[DLY_FIELD_W*pos_reg[1:0] +: DLY_FIELD_W];

        req.valid     = accept;
        req.routed    = routed;
        req.frame_end = frame_end;
        req.tgt       = route_nib[OUT_IDX_W-1:0];
        req.gain      = gain;
        req.n         = eff_n;
    end

    assign sample_ch.ready = !hold_reg && bank_free;
    assign accept          = sample_ch.valid && sample_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg          <= CC_RST;
            gains_low_reg   <= GAINS_RST;
            gains_high_reg  <= GAINS_RST;
            delays_low_reg  <= DELAYS_RST;
            delays_high_reg <= DELAYS_RST;
            route_reg       <= ROUTE_RST;
            pos_reg         <= '0;
            hold_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_CHANNEL_COUNT: cc_reg          <= cfg_data[CNT_W-1:0];
                    REG_GAINS_LOW:     gains_low_reg   <= cfg_data;
                    REG_GAINS_HIGH:    gains_high_reg  <= cfg_data;
                    REG_DELAYS_LOW:    delays_low_reg  <= cfg_data[47:0];
                    REG_DELAYS_HIGH:   delays_high_reg <= cfg_data[47:0];
                    REG_ROUTE_TABLE:   route_reg       <= cfg_data[31:0];
                    default:           ;
                endcase
            end
            hold_reg <= accept;
            if (accept)
            begin
                pos_reg <= frame_end ? '0 : pos_reg + POS_W'(1);
            end
        end
    end

    cdgr_delay #(
        .MAX_CHANNELS_P (MAX_CHANNELS_P),
        .MAX_DELAY      (MAX_DELAY),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_delay (
        .clk        (clk),
        .rst_n      (rst_n),
        .we         (accept && routed),
        .pos        (pos_reg),
        .len_field  (len_field),
        .sample     (sample_ch.sample_in),
        .old_sample (old_sample)
    );

    cdgr_mix #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .GAIN_FRAC   (GAIN_FRAC)
    ) u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .old_sample (old_sample),
        .bank_free  (bank_free),
        .mix_ch     (mix_ch)
    );

endmodule

FILE: test/cdgr_mix_checker.sv
`timescale 1ns / 100ps
// checker for the delay-gain router: follows register writes and input beats,
// predicts each mixed output beat and compares the outputs in order
// depends on cdgr_pkg
module cdgr_mix_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [cdgr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdgr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [23:0]                     in_sample,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [23:0]                     out_sample,
    input  logic [2:0]                      out_channel,
    input  logic                            out_frame_last,
    output int                              fail_count,
    output int                              pending
);
    import cdgr_pkg::*;

    localparam int LINE_DEPTH = MAX_DELAY_DEF;

    typedef struct packed {
        logic signed [23:0] sample;
        logic [2:0]         chan;
        logic               last;
    } mix_beat_t;

    logic [CNT_W-1:0]   chan_count_r;
    logic [63:0]        gains_lo_r;
    logic [63:0]        gains_hi_r;
    logic [47:0]        delays_lo_r;
    logic [47:0]        delays_hi_r;
    logic [31:0]        route_r;

    logic signed [23:0] line_mem [NUM_POS*LINE_DEPTH];
    logic [11:0]        line_ptr [NUM_POS];
    longint             mix_acc [NUM_OUT];
    logic [2:0]         frame_pos;
    mix_beat_t          mix_expect_q [$];

    function automatic longint clamp_signed(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mix check: %s", $time, msg);
        fail_count++;
    endtask

    task automatic mix_sample(input logic signed [23:0] s);
        int          n;
        int          p;
        int          ptr;
        int          len;
        logic [3:0]  route;
        logic [127:0] gains;
        logic [95:0] delays;
        longint      old;
        longint      gain;
        longint      prod;
        mix_beat_t   beat;
        gains  = {gains_hi_r, gains_lo_r};
        delays = {delays_hi_r, delays_lo_r};
        n = int'(chan_count_r);
        if (n == 0)
            n = 1;
        if (n > NUM_POS)
            n = NUM_POS;
        p = int'(frame_pos);
        route = route_r[4*p +: 4];
        if (route[3])
        begin
            gain = longint'($signed(gains[16*p +: 16]));
            len  = int'(delays[12*p +: 12]) + 1;
            if (len > LINE_DEPTH)
                len = LINE_DEPTH;
            ptr  = int'(line_ptr[p]);
            old  = line_mem[p*LINE_DEPTH + ptr];
            line_mem[p*LINE_DEPTH + ptr] = s;
            ptr++;
            if (ptr >= len)
                ptr = 0;
            line_ptr[p] = 12'(ptr);
            prod = (old * gain + (longint'(1) <<< (GAIN_FRAC_DEF - 1))) >>> GAIN_FRAC_DEF;
            mix_acc[route[2:0]] = clamp_signed(mix_acc[route[2:0]] + prod, ACC_W);
        end
        if (p + 1 >= n)
        begin
            for (int c = 0; c < n; c++)
            begin
                beat.sample = 24'(clamp_signed(mix_acc[c], 24));
                beat.chan   = 3'(c);
                beat.last   = (c == n - 1);
                mix_expect_q.push_back(beat);
            end
            for (int c = 0; c < NUM_OUT; c++)
                mix_acc[c] = 0;
            frame_pos = '0;
        end
        else
        begin
            frame_pos = 3'(p + 1);
        end
    endtask

    task automatic check_beat();
        mix_beat_t want;
        if (mix_expect_q.size() == 0)
        begin
            report_mismatch($sformatf("output beat on channel %0d with nothing expected",
                                      out_channel));
        end
        else
        begin
            want = mix_expect_q.pop_front();
            if ($signed(out_sample) != want.sample)
                report_mismatch($sformatf("sample_out got %0d want %0d (channel %0d)",
                                          $signed(out_sample), want.sample, want.chan));
            if (out_channel != want.chan)
                report_mismatch($sformatf("out_channel got %0d want %0d",
                                          out_channel, want.chan));
            if (out_frame_last != want.last)
                report_mismatch($sformatf("frame_last got %0b want %0b (channel %0d)",
                                          out_frame_last, want.last, want.chan));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_r = CC_RST;
            gains_lo_r   = GAINS_RST;
            gains_hi_r   = GAINS_RST;
            delays_lo_r  = DELAYS_RST;
            delays_hi_r  = DELAYS_RST;
            route_r      = ROUTE_RST;
            for (int i = 0; i < NUM_POS*LINE_DEPTH; i++)
                line_mem[i] = '0;
            for (int i = 0; i < NUM_POS; i++)
                line_ptr[i] = '0;
            for (int i = 0; i < NUM_OUT; i++)
                mix_acc[i] = 0;
            frame_pos = '0;
            mix_expect_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_CHANNEL_COUNT: chan_count_r = cfg_data[3:0];
                    REG_GAINS_LOW:     gains_lo_r   = cfg_data;
                    REG_GAINS_HIGH:    gains_hi_r   = cfg_data;
                    REG_DELAYS_LOW:    delays_lo_r  = cfg_data[47:0];
                    REG_DELAYS_HIGH:   delays_hi_r  = cfg_data[47:0];
                    REG_ROUTE_TABLE:   route_r      = cfg_data[31:0];
                    default:           ;
                endcase
            end
            if (in_valid && in_ready)
                mix_sample($signed(in_sample));
            if (out_valid && out_ready)
                check_beat();
            pending = mix_expect_q.size();
        end
    end

endmodule

FILE: test/tb_channel_delay_gain_router.sv
`timescale 1ns / 100ps
// top of the delay-gain router testbench: clock, reset, register writes and
// sample stimulus under several idle patterns; verdict from cdgr_mix_checker
// depends on cdgr_pkg, cdgr_if, cdgr_mix_checker and the router RTL
module tb_channel_delay_gain_router;
    import cdgr_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 20;
    localparam int PHASE_ITEMS  = 31;
    localparam logic [CFG_IDX_W-1:0] UNUSED_REG = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    send_idle_pct;
    int                    recv_stall_pct;
    int                    cycle_count;
    int                    fail_count;
    int                    pending;

    cdgr_in_if  in_if ();
    cdgr_out_if out_if ();

    always #5 clk = ~clk;

    channel_delay_gain_router u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (in_if),
        .mix_ch    (out_if)
    );

    cdgr_mix_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wen        (cfg_wen),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_if.valid),
        .in_ready       (in_if.ready),
        .in_sample      (in_if.sample_in),
        .out_valid      (out_if.valid),
        .out_ready      (out_if.ready),
        .out_sample     (out_if.sample_out),
        .out_channel    (out_if.out_channel),
        .out_frame_last (out_if.frame_last),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always @(negedge clk)
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_sample(input logic [23:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_in <= s;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // let every expected beat drain, then cover the pipeline latency
    task automatic drain();
        in_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (HOLD_CYCLES) @(negedge clk);
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(9))
            0:       return 24'h7F_FFFF;
            1:       return 24'h80_0000;
            2:       return 24'h00_0000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_config();
        logic [CFG_DATA_W-1:0] d;
        d = {$urandom, $urandom};
        if ($urandom_range(9) < 8)
            d[3:0] = 4'($urandom_range(8, 1));
        write_reg(REG_CHANNEL_COUNT, d);
        write_reg(REG_GAINS_LOW, {$urandom, $urandom});
        write_reg(REG_GAINS_HIGH, {$urandom, $urandom});
        for (int k = 0; k < 2; k++)
        begin
            d = {$urandom, $urandom};
            for (int j = 0; j < 4; j++)
                d[12*j +: 12] = ($urandom_range(9) == 0) ? 12'($urandom_range(4095))
                                                         : 12'($urandom_range(7));
            write_reg((k == 0) ? REG_DELAYS_LOW : REG_DELAYS_HIGH, d);
        end
        d = {$urandom, $urandom};
        if ($urandom_range(9) < 7)
            d[31:0] = d[31:0] | 32'h8888_8888;
        write_reg(REG_ROUTE_TABLE, d);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_wen         = 1'b0;
        cfg_index       = REG_CHANNEL_COUNT;
        cfg_data        = '0;
        in_if.valid     = 1'b0;
        in_if.sample_in = '0;
        out_if.ready    = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings, sample extremes
        send_sample(24'h7F_FFFF);
        send_sample(24'h80_0000);
        send_sample(24'h00_0000);
        send_sample(24'hFF_FFFF);
        drain();

        // full frame, most negative gain, every position into output zero
        write_reg(REG_CHANNEL_COUNT, 64'd8);
        write_reg(REG_GAINS_LOW, 64'h8000_8000_8000_8000);
        write_reg(REG_GAINS_HIGH, 64'h8000_8000_8000_8000);
        write_reg(REG_ROUTE_TABLE, 64'h8888_8888);
        repeat (16) send_sample(24'h80_0000);
        drain();

        // zero count, unrouted position
        write_reg(REG_CHANNEL_COUNT, 64'd0);
        write_reg(REG_ROUTE_TABLE, 64'h0000_0007);
        send_sample(24'h7F_FFFF);
        drain();

        // count above eight, longer lines, count lowered mid-frame
        write_reg(REG_CHANNEL_COUNT, 64'hF);
        write_reg(REG_ROUTE_TABLE, 64'h9E9E_9E9E);
        write_reg(REG_GAINS_LOW, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_GAINS_HIGH, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_DELAYS_LOW, 64'h0000_0070_0700_7007);
        write_reg(REG_DELAYS_HIGH, 64'h0000_0070_0700_7007);
        write_reg(UNUSED_REG, '1);
        repeat (3) send_sample(24'h7F_FFFF);
        drain();
        write_reg(REG_CHANNEL_COUNT, 64'd2);
        send_sample(24'h12_3456);
        drain();

        // delay shortened below the current pointer
        write_reg(REG_DELAYS_LOW, 64'd0);
        write_reg(REG_DELAYS_HIGH, 64'd0);
        send_sample(24'h80_0000);
        send_sample(24'h7F_FFFF);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            random_config();
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                send_sample(pick_sample());
                if (i == PHASE_ITEMS / 2 && $urandom_range(1) == 1)
                    drain();
            end
            drain();
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/cdgr_pkg.sv
hdl/cdgr_if.sv
hdl/cdgr_delay.sv
hdl/cdgr_mix.sv
hdl/channel_delay_gain_router.sv
test/cdgr_mix_checker.sv
test/tb_channel_delay_gain_router.sv
